// ===== hw/rtl/ngte_pkg.sv =====
package ngte_pkg;

   localparam int unsigned TIME_LEN    = 10;
   localparam int unsigned HDR_LEN     = 6;
   localparam int unsigned Q_DEPTH_DEF = 2;

   localparam logic [7:0] START_CHAR = 8'h24;
   localparam logic [3:0] CAP_LAST   = 4'(TIME_LEN - 1);
   localparam logic [2:0] HDR_LAST   = 3'(HDR_LEN - 1);

   typedef struct packed {
      logic       is_first;
      logic [7:0] h0;
      logic [7:0] h1;
      logic [7:0] m0;
      logic [7:0] m1;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] f0;
      logic [7:0] f1;
      logic [7:0] f2;
   } time_rec_type;

   function automatic logic [7:0] gga_tag_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = "G";
         3'd1: c = "P";
         3'd2: c = "G";
         3'd3: c = "G";
         3'd4: c = "A";
         3'd5: c = ",";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/ngte_if.sv =====
interface ngte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ngte_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] hours;
   logic [6:0] minutes;
   logic [6:0] seconds;
   logic [9:0] millis;
   logic       is_first;

   modport source (output valid, output hours, output minutes, output seconds,
                   output millis, output is_first, input ready);
   modport sink (input valid, input hours, input minutes, input seconds,
                 input millis, input is_first, output ready);
endinterface

// ===== hw/rtl/ngte_front.sv =====
module ngte_front import ngte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ngte_req_if.sink       req,
   input  logic           q_full,
   output logic           push,
   output time_rec_type   push_rec
);

   logic       capture_active_ff, capture_active_in;
   logic [3:0] capture_pos_ff, capture_pos_in;
   logic       header_active_ff, header_active_in;
   logic [2:0] header_pos_ff, header_pos_in;
   logic       header_match_ff, header_match_in;
   logic       first_pending_ff, first_pending_in;
   logic [7:0] time_chars_ff [TIME_LEN-1];

   logic fire;
   logic cap_done;
   logic hdr_done;
   logic tag_ok;

   assign req.ready = !q_full;

   always_comb begin
      fire     = req.valid && !q_full;
      cap_done = capture_active_ff && (capture_pos_ff == CAP_LAST);
      hdr_done = header_active_ff && (header_pos_ff == HDR_LAST);
      tag_ok   = (req.rx_byte == gga_tag_char(header_pos_ff));

      capture_active_in = capture_active_ff;
      capture_pos_in    = capture_pos_ff;
      header_active_in  = header_active_ff;
      header_pos_in     = header_pos_ff;
      header_match_in   = header_match_ff;
      first_pending_in  = first_pending_ff;

      if (fire) begin
         if (capture_active_ff) begin
            if (cap_done) begin
               capture_active_in = 1'b0;
               capture_pos_in    = 4'd0;
               first_pending_in  = 1'b0;
            end else begin
               capture_pos_in = capture_pos_ff + 4'd1;
            end
         end
         if (header_active_ff) begin
            if (hdr_done) begin
               header_active_in = 1'b0;
               header_pos_in    = 3'd0;
               header_match_in  = 1'b1;
               if (header_match_ff && tag_ok) begin
                  capture_active_in = 1'b1;
               end
            end else begin
               header_pos_in   = header_pos_ff + 3'd1;
               header_match_in = header_match_ff && tag_ok;
            end
         end
         if (req.rx_byte == START_CHAR) begin
            header_active_in = 1'b1;
         end
      end
   end

   assign push = fire && cap_done;

   always_comb begin
      push_rec.is_first = first_pending_ff;
      push_rec.h0       = time_chars_ff[0];
      push_rec.h1       = time_chars_ff[1];
      push_rec.m0       = time_chars_ff[2];
      push_rec.m1       = time_chars_ff[3];
      push_rec.s0       = time_chars_ff[4];
      push_rec.s1       = time_chars_ff[5];
      push_rec.f0       = time_chars_ff[7];
      push_rec.f1       = time_chars_ff[8];
      push_rec.f2       = req.rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_active_ff <= 1'b0;
         capture_pos_ff    <= 4'd0;
         header_active_ff  <= 1'b0;
         header_pos_ff     <= 3'd0;
         header_match_ff   <= 1'b1;
         first_pending_ff  <= 1'b1;
      end else begin
         capture_active_ff <= capture_active_in;
         capture_pos_ff    <= capture_pos_in;
         header_active_ff  <= header_active_in;
         header_pos_ff     <= header_pos_in;
         header_match_ff   <= header_match_in;
         first_pending_ff  <= first_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TIME_LEN - 1; i++) begin
         if (fire && capture_active_ff && (capture_pos_ff == 4'(i))) begin
            time_chars_ff[i] <= req.rx_byte;
         end
      end
   end

`ifndef SYNTHESIS
   a_cap_pos_range: assert property (@(posedge clock) disable iff (reset)
      capture_pos_ff <= CAP_LAST) else $error("capture position out of range");
`endif
`ifndef SYNTHESIS
   a_hdr_pos_range: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff <= HDR_LAST) else $error("header position out of range");
`endif
`ifndef SYNTHESIS
   a_first_once: assert property (@(posedge clock) disable iff (reset)
      push |=> !first_pending_ff) else $error("sync mark not cleared after word");
`endif

endmodule

// ===== hw/rtl/ngte_queue.sv =====
module ngte_queue import ngte_pkg::*; #(
   parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  time_rec_type wr_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output time_rec_type rd_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   time_rec_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign rd_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("push into full queue");
`endif
`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/ngte_back.sv =====
module ngte_back import ngte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  time_rec_type q_data,
   output logic         pop,
   ngte_rsp_if.source   rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] hours_ff, minutes_ff, seconds_ff;
   logic [9:0] millis_ff;
   logic       is_first_ff;
   logic       load;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic [6:0] two_val(input logic [7:0] c0, input logic [7:0] c1);
      logic [6:0] d0;
      logic [6:0] d1;
      logic [6:0] v;
      d0 = {3'b000, c0[3:0]};
      d1 = {3'b000, c1[3:0]};
      if (!is_digit(c0)) begin
         v = 7'd0;
      end else if (!is_digit(c1)) begin
         v = d0;
      end else begin
         v = d0 * 7'd10 + d1;
      end
      return v;
   endfunction

   function automatic logic [9:0] three_val(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2);
      logic [9:0] d0;
      logic [9:0] d1;
      logic [9:0] d2;
      logic [9:0] v;
      d0 = {6'b000000, c0[3:0]};
      d1 = {6'b000000, c1[3:0]};
      d2 = {6'b000000, c2[3:0]};
      if (!is_digit(c0)) begin
         v = 10'd0;
      end else if (!is_digit(c1)) begin
         v = d0;
      end else if (!is_digit(c2)) begin
         v = d0 * 10'd10 + d1;
      end else begin
         v = d0 * 10'd100 + d1 * 10'd10 + d2;
      end
      return v;
   endfunction

   assign load = q_not_empty && (!rsp_valid_ff || rsp.ready);
   assign pop  = load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hours_ff    <= two_val(q_data.h0, q_data.h1);
         minutes_ff  <= two_val(q_data.m0, q_data.m1);
         seconds_ff  <= two_val(q_data.s0, q_data.s1);
         millis_ff   <= three_val(q_data.f0, q_data.f1, q_data.f2);
         is_first_ff <= q_data.is_first;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.hours    = hours_ff;
   assign rsp.minutes  = minutes_ff;
   assign rsp.seconds  = seconds_ff;
   assign rsp.millis   = millis_ff;
   assign rsp.is_first = is_first_ff;

`ifndef SYNTHESIS
   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !load) else $error("output word overwritten");
`endif

endmodule

// ===== hw/rtl/nmea_gga_time_extractor_top.sv =====
// Channel   Direction  Word
// req       in         rx_byte
// rsp       out        hours, minutes, seconds, millis, is_first
//
// One byte is accepted per cycle while the queue is not full; the tenth time character
// pushes a time word into the queue, then into the rsp output register once that is free.
// The front parser and the digit converter are parted by a queue of QUEUE_DEPTH words.
// req.ready drops only while that queue is full; rsp stalls back up into it.
// Synchronous reset clears parser state, queue pointers and output valid.
module nmea_gga_time_extractor_top import ngte_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   ngte_req_if.sink    req_port,
   ngte_rsp_if.source  rsp_port
);

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_not_empty;
   time_rec_type q_wr_data;
   time_rec_type q_rd_data;

   ngte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_port),
      .q_full   (q_full),
      .push     (q_push),
      .push_rec (q_wr_data)
   );

   ngte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   ngte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_rd_data),
      .pop         (q_pop),
      .rsp         (rsp_port)
   );

endmodule
